// ===== design/tlik_pkg.sv =====
// Shared types, constants and small functions for the two-link leg solver.
// Used by every module of the solver; no dependencies.
`default_nettype none

package tlik_pkg;

    // field widths
    localparam int COORD_W = 16;
    localparam int LEN_W   = 15;
    localparam int HIP_W   = 16;
    localparam int KNEE_W  = 14;
    localparam int CFG_IDX_W = 2;

    // default cordic depth
    localparam int CORDIC_ITER_DEF = 16;
    localparam int ATAN_LEN = 24;

    // internal datapath widths
    localparam int D2_W   = 32;  // x^2 + y^2
    localparam int NV_W   = 34;  // signed cordic operands
    localparam int RAD_W  = 62;  // radicand of the square root
    localparam int ROOT_W = 31;  // square root result
    localparam int SQRT_STAGES = 31;
    localparam int XW   = 38;    // cordic vector width
    localparam int ZW   = 34;    // cordic angle, radians Q30
    localparam int HZ_W = 35;    // hip angle difference
    localparam int OUT_W = 18;   // converted angle before clamping

    localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic [27:0] DEG_Q16 = 28'd240315917;  // 11520/pi in Q16

    localparam logic signed [OUT_W-1:0] HIP_LIMIT  = 18'sd25736;
    localparam logic signed [OUT_W-1:0] KNEE_LIMIT = 18'sd12868;

    // register reset values
    localparam logic [LEN_W-1:0] LEN_RESET = 15'd1600;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER_LEN = 2'd0,
        CFG_LOWER_LEN = 2'd1,
        CFG_DEG_MODE  = 2'd2
    } cfg_index_t;

    // control carried alongside the angle datapath
    typedef struct packed {
        logic valid;
        logic reach;
    } side_t;

    // operands carried around the square root
    typedef struct packed {
        logic                     reach;
        logic signed [NV_W-1:0]   n;
        logic signed [NV_W-1:0]   m;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } front_t;

    // arctangent of 2^-i in radians Q30
    function automatic logic [29:0] atan_q30(input int idx);
        logic [29:0] v;
        case (idx)
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // left shift that brings the leading one of v up to bit 30
    function automatic logic [4:0] norm_shift(input logic [29:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int i = 0; i < 30; i++)
        begin
            if (v[i])
                pos = 5'(i);
        end
        return 5'd30 - pos;
    endfunction

endpackage

`default_nettype wire

// ===== design/two_link_ik_solver_top.sv =====
// Two-link planar leg solver: reach test, square root, three cordics, unit output.
// Depends on tlik_pkg, tlik_isqrt, tlik_cordic and tlik_out.
//
//  port group                   dir  beat marked by      meaning
//  start foot_x foot_y          in   start && !busy      foot target, mm Q12.4
//  cfg_we cfg_index cfg_data    in   cfg_we              link lengths, angle unit
//  done reachable hip/knee      out  done (one cycle)    joint angles
//
// One beat is taken every cycle; busy stays low.
// Each result passes through the 31-stage square root and the cordic pipeline;
// results leave in arrival order. The receiver cannot stall, so the pipeline never holds.
// rst_n clears valid bits and the configuration registers.
// Configuration must be written only while idle; the block does not enforce this.
`default_nettype none

module two_link_ik_solver_top #(
    parameter int CORDIC_ITERATIONS = tlik_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    output logic                                       busy,
    input  wire logic signed [tlik_pkg::COORD_W-1:0]   foot_x,
    input  wire logic signed [tlik_pkg::COORD_W-1:0]   foot_y,
    input  wire logic                                  cfg_we,
    input  wire logic        [tlik_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic        [tlik_pkg::LEN_W-1:0]     cfg_data,
    output logic                                       done,
    output logic                                       reachable,
    output logic signed [tlik_pkg::HIP_W-1:0]          hip_angle,
    output logic        [tlik_pkg::KNEE_W-1:0]         knee_angle
);
    import tlik_pkg::*;

    localparam int CLAT = CORDIC_ITERATIONS + 3;
    localparam int LATENCY = 4 + SQRT_STAGES + CLAT + 1 + 2;

    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration registers
    logic [LEN_W-1:0] upper_reg;
    logic [LEN_W-1:0] lower_reg;
    logic             deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg <= LEN_RESET;
            lower_reg <= LEN_RESET;
            deg_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UPPER_LEN: upper_reg <= cfg_data;
                CFG_LOWER_LEN: lower_reg <= cfg_data;
                CFG_DEG_MODE:  deg_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // terms that follow from the link lengths
    logic [LEN_W:0]   len_sum;
    logic [LEN_W-1:0] len_diff;
    logic [29:0]      l1l2;
    logic [29:0]      l1sq_reg;
    logic [29:0]      l2sq_reg;
    logic [31:0]      sumsq_reg;
    logic [29:0]      diffsq_reg;
    logic [30:0]      p_reg;
    logic [RAD_W-1:0] psq_reg;

    assign len_sum  = {1'b0, upper_reg} + {1'b0, lower_reg};
    assign len_diff = (upper_reg >= lower_reg) ? upper_reg - lower_reg : lower_reg - upper_reg;
    assign l1l2     = upper_reg * lower_reg;

    always_ff @(posedge clk)
    begin
        l1sq_reg   <= upper_reg * upper_reg;
        l2sq_reg   <= lower_reg * lower_reg;
        sumsq_reg  <= len_sum * len_sum;
        diffsq_reg <= len_diff * len_diff;
        p_reg      <= {l1l2, 1'b0};
        psq_reg    <= p_reg * p_reg;
    end

    // stage 1: input capture
    logic                      v1_reg;
    logic signed [COORD_W-1:0] x1_reg;
    logic signed [COORD_W-1:0] y1_reg;

    // stage 2: squared distance
    logic                      v2_reg;
    logic [D2_W-1:0]           d2_reg;
    logic signed [COORD_W-1:0] x2_reg;
    logic signed [COORD_W-1:0] y2_reg;
    logic signed [31:0]        xsq;
    logic signed [31:0]        ysq;

    assign xsq = x1_reg * x1_reg;
    assign ysq = y1_reg * y1_reg;

    // stage 3: reach test and law of cosines terms
    logic                   v3_reg;
    front_t                 f3_reg;
    logic [31:0]            nmag3_reg;
    front_t                 f3_next;
    logic signed [NV_W-1:0] d2s;
    logic signed [NV_W-1:0] n3;

    assign d2s = $signed({2'b0, d2_reg});
    assign n3  = d2s - $signed({4'b0, l1sq_reg}) - $signed({4'b0, l2sq_reg});

    always_comb
    begin
        f3_next.reach = (d2_reg <= sumsq_reg) && (d2_reg >= {2'b0, diffsq_reg});
        f3_next.n     = n3;
        f3_next.m     = d2s + $signed({4'b0, l1sq_reg}) - $signed({4'b0, l2sq_reg});
        f3_next.x     = x2_reg;
        f3_next.y     = y2_reg;
    end

    // stage 4: radicand p^2 - n^2
    logic             v4_reg;
    front_t           f4_reg;
    logic [RAD_W-1:0] rad4_reg;
    logic [63:0]      nsq;
    logic [63:0]      rad_full;

    assign nsq      = nmag3_reg * nmag3_reg;
    assign rad_full = {2'b0, psq_reg} - nsq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_reg    <= foot_x;
        y1_reg    <= foot_y;
        d2_reg    <= 32'(xsq) + 32'(ysq);
        x2_reg    <= x1_reg;
        y2_reg    <= y1_reg;
        f3_reg    <= f3_next;
        nmag3_reg <= (n3 < 0) ? 32'(-n3) : 32'(n3);
        f4_reg    <= f3_reg;
        rad4_reg  <= rad_full[RAD_W-1:0];
    end

    // square root, operands travel alongside
    logic [ROOT_W-1:0] root;
    front_t            fq_reg [0:SQRT_STAGES-1];
    logic              vq_reg [0:SQRT_STAGES-1];

    tlik_isqrt u_isqrt (
        .clk  (clk),
        .rad  (rad4_reg),
        .root (root)
    );

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_sq_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vq_reg[i] <= 1'b0;
            else
                vq_reg[i] <= (i == 0) ? v4_reg : vq_reg[(i == 0) ? 0 : i-1];
        end

        always_ff @(posedge clk)
        begin
            fq_reg[i] <= (i == 0) ? f4_reg : fq_reg[(i == 0) ? 0 : i-1];
        end
    end

    // three cordics: knee, offset angle and foot direction
    front_t                 fq;
    logic signed [NV_W-1:0] s_op;
    logic signed [NV_W-1:0] negy_op;
    logic signed [NV_W-1:0] x_op;
    logic signed [ZW-1:0]   knee_zc;
    logic signed [ZW-1:0]   alpha_zc;
    logic signed [ZW-1:0]   foot_zc;

    assign fq      = fq_reg[SQRT_STAGES-1];
    assign s_op    = $signed({3'b0, root});
    assign negy_op = -NV_W'(fq.y);
    assign x_op    = NV_W'(fq.x);

    tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_knee (
        .clk   (clk),
        .in_y  (s_op),
        .in_x  (fq.n),
        .angle (knee_zc)
    );

    tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_alpha (
        .clk   (clk),
        .in_y  (s_op),
        .in_x  (fq.m),
        .angle (alpha_zc)
    );

    tlik_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic_foot (
        .clk   (clk),
        .in_y  (negy_op),
        .in_x  (x_op),
        .angle (foot_zc)
    );

    // valid and reach follow the cordic depth
    side_t sc_reg [0:CLAT-1];
    side_t sq_side;

    assign sq_side.valid = vq_reg[SQRT_STAGES-1];
    assign sq_side.reach = fq.reach;

    for (genvar i = 0; i < CLAT; i++)
    begin : g_cd_side
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sc_reg[i] <= '0;
            else
                sc_reg[i] <= (i == 0) ? sq_side : sc_reg[(i == 0) ? 0 : i-1];
        end
    end

    // hip angle is foot direction minus offset
    logic signed [HZ_W-1:0] hip_z_reg;
    logic signed [ZW-1:0]   knee_z_reg;
    side_t                  sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sh_reg <= '0;
        else
            sh_reg <= sc_reg[CLAT-1];
    end

    always_ff @(posedge clk)
    begin
        hip_z_reg  <= HZ_W'(foot_zc) - HZ_W'(alpha_zc);
        knee_z_reg <= knee_zc;
    end

    tlik_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .deg        (deg_reg),
        .side       (sh_reg),
        .knee_z     (knee_z_reg),
        .hip_z      (hip_z_reg),
        .done       (done),
        .reachable  (reachable),
        .hip_angle  (hip_angle),
        .knee_angle (knee_angle)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##(LATENCY) done)
        else $error("accepted beat did not produce a result on time");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching input beat");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !reachable) |-> (hip_angle == '0 && knee_angle == '0))
        else $error("unreachable target with nonzero angles");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($signed({2'b0, knee_angle}) <= KNEE_LIMIT
                  && $signed(OUT_W'(hip_angle)) <= HIP_LIMIT
                  && $signed(OUT_W'(hip_angle)) >= -HIP_LIMIT))
        else $error("angle outside clamp range");
`endif

endmodule

`default_nettype wire

// ===== design/tlik_isqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on tlik_pkg for widths and stage count.
`default_nettype none

module tlik_isqrt (
    input  wire logic                        clk,
    input  wire logic [tlik_pkg::RAD_W-1:0]  rad,
    output logic      [tlik_pkg::ROOT_W-1:0] root
);
    import tlik_pkg::*;

    logic [RAD_W-1:0] v_reg [0:SQRT_STAGES-1];
    logic [RAD_W-1:0] r_reg [0:SQRT_STAGES-1];

    for (genvar i = 0; i < SQRT_STAGES; i++)
    begin : g_stage
        localparam logic [RAD_W:0] BIT = (RAD_W+1)'(1) << (60 - 2 * i);
        logic [RAD_W-1:0] v_in;
        logic [RAD_W-1:0] r_in;
        logic [RAD_W:0]   trial;
        logic [RAD_W-1:0] v_next;
        logic [RAD_W-1:0] r_next;

        if (i == 0)
        begin : g_first
            assign v_in = rad;
            assign r_in = '0;
        end
        else
        begin : g_rest
            assign v_in = v_reg[i-1];
            assign r_in = r_reg[i-1];
        end

        // restoring step: subtract when the trial fits
        always_comb
        begin
            trial = {1'b0, r_in} + BIT;
            if ({1'b0, v_in} >= trial)
            begin
                v_next = RAD_W'({1'b0, v_in} - trial);
                r_next = RAD_W'((r_in >> 1) + BIT[RAD_W-1:0]);
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            v_reg[i] <= v_next;
            r_reg[i] <= r_next;
        end
    end

    assign root = r_reg[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

`default_nettype wire

// ===== design/tlik_cordic.sv =====
// Pipelined vectoring cordic giving atan2(y, x) in radians Q30.
// Depends on tlik_pkg for widths, the arctangent table and the shift search.
`default_nettype none

module tlik_cordic #(
    parameter int ITER = tlik_pkg::CORDIC_ITER_DEF
) (
    input  wire logic                              clk,
    input  wire logic signed [tlik_pkg::NV_W-1:0]  in_y,
    input  wire logic signed [tlik_pkg::NV_W-1:0]  in_x,
    output logic      signed [tlik_pkg::ZW-1:0]    angle
);
    import tlik_pkg::*;

    // stage 0: axis cases and quadrant fold
    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;
    logic signed [XW-1:0] x0_next;
    logic signed [XW-1:0] y0_next;
    logic signed [ZW-1:0] z0_next;
    logic                 ov0_next;
    logic signed [ZW-1:0] ovz0_next;

    logic signed [XW-1:0] x0_reg;
    logic signed [XW-1:0] y0_reg;
    logic signed [ZW-1:0] z0_reg;
    logic                 ov0_reg;
    logic signed [ZW-1:0] ovz0_reg;

    assign xe = XW'(in_x);
    assign ye = XW'(in_y);

    always_comb
    begin
        ov0_next = (in_y == '0) || (in_x == '0);
        if (in_y == '0)
            ovz0_next = (in_x < 0) ? PI_Q30 : '0;
        else
            ovz0_next = (in_y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;

        if (in_x < 0)
        begin
            if (in_y > 0)
            begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = HALF_PI_Q30;
            end
            else
            begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -HALF_PI_Q30;
            end
        end
        else
        begin
            x0_next = xe;
            y0_next = ye;
            z0_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg   <= x0_next;
        y0_reg   <= y0_next;
        z0_reg   <= z0_next;
        ov0_reg  <= ov0_next;
        ovz0_reg <= ovz0_next;
    end

    // stage 1: find the normalizing shift
    logic [XW-1:0]        mag;
    logic [4:0]           k1_next;
    logic signed [XW-1:0] x1_reg;
    logic signed [XW-1:0] y1_reg;
    logic signed [ZW-1:0] z1_reg;
    logic                 ov1_reg;
    logic signed [ZW-1:0] ovz1_reg;
    logic [4:0]           k1_reg;

    always_comb
    begin
        mag = x0_reg | ((y0_reg < 0) ? -y0_reg : y0_reg);
        if (|mag[XW-1:30])
            k1_next = '0;
        else
            k1_next = norm_shift(mag[29:0]);
    end

    always_ff @(posedge clk)
    begin
        x1_reg   <= x0_reg;
        y1_reg   <= y0_reg;
        z1_reg   <= z0_reg;
        ov1_reg  <= ov0_reg;
        ovz1_reg <= ovz0_reg;
        k1_reg   <= k1_next;
    end

    // stage 2: apply the shift
    logic signed [XW-1:0] x2_reg;
    logic signed [XW-1:0] y2_reg;
    logic signed [ZW-1:0] z2_reg;
    logic                 ov2_reg;
    logic signed [ZW-1:0] ovz2_reg;

    always_ff @(posedge clk)
    begin
        x2_reg   <= x1_reg <<< k1_reg;
        y2_reg   <= y1_reg <<< k1_reg;
        z2_reg   <= z1_reg;
        ov2_reg  <= ov1_reg;
        ovz2_reg <= ovz1_reg;
    end

    // micro-rotations, one per stage
    logic signed [XW-1:0] xi_reg  [0:ITER-1];
    logic signed [XW-1:0] yi_reg  [0:ITER-1];
    logic signed [ZW-1:0] zi_reg  [0:ITER-1];
    logic                 ovi_reg [0:ITER-1];
    logic signed [ZW-1:0] ovzi_reg[0:ITER-1];

    for (genvar i = 0; i < ITER; i++)
    begin : g_iter
        localparam logic signed [ZW-1:0] STEP = ZW'(atan_q30(i));
        logic signed [XW-1:0] x_in;
        logic signed [XW-1:0] y_in;
        logic signed [ZW-1:0] z_in;
        logic                 ov_in;
        logic signed [ZW-1:0] ovz_in;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;

        if (i == 0)
        begin : g_first
            assign x_in   = x2_reg;
            assign y_in   = y2_reg;
            assign z_in   = z2_reg;
            assign ov_in  = ov2_reg;
            assign ovz_in = ovz2_reg;
        end
        else
        begin : g_rest
            assign x_in   = xi_reg[i-1];
            assign y_in   = yi_reg[i-1];
            assign z_in   = zi_reg[i-1];
            assign ov_in  = ovi_reg[i-1];
            assign ovz_in = ovzi_reg[i-1];
        end

        assign dx = y_in >>> i;
        assign dy = x_in >>> i;

        always_ff @(posedge clk)
        begin
            if (y_in < 0)
            begin
                xi_reg[i] <= x_in - dx;
                yi_reg[i] <= y_in + dy;
                zi_reg[i] <= z_in - STEP;
            end
            else
            begin
                xi_reg[i] <= x_in + dx;
                yi_reg[i] <= y_in - dy;
                zi_reg[i] <= z_in + STEP;
            end
            ovi_reg[i]  <= ov_in;
            ovzi_reg[i] <= ovz_in;
        end
    end

    // axis cases take the exact angle
    assign angle = ovi_reg[ITER-1] ? ovzi_reg[ITER-1] : zi_reg[ITER-1];

endmodule

`default_nettype wire

// ===== design/tlik_out.sv =====
// Angle unit conversion, rounding, clamping and result registers.
// Depends on tlik_pkg for widths, limits and the side_t struct.
`default_nettype none

module tlik_out (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              deg,
    input  wire tlik_pkg::side_t                   side,
    input  wire logic signed [tlik_pkg::ZW-1:0]    knee_z,
    input  wire logic signed [tlik_pkg::HZ_W-1:0]  hip_z,
    output logic                                   done,
    output logic                                   reachable,
    output logic signed [tlik_pkg::HIP_W-1:0]      hip_angle,
    output logic        [tlik_pkg::KNEE_W-1:0]     knee_angle
);
    import tlik_pkg::*;

    localparam logic signed [63:0] DEG_HALF = 64'sd35184372088832;  // 2^45

    // lane 0 is the hip, lane 1 the knee
    logic signed [HZ_W-1:0]  z_in   [0:1];
    logic signed [46:0]      ph_reg [0:1];
    logic        [44:0]      pl_reg [0:1];
    logic signed [OUT_W-1:0] rr_reg [0:1];
    logic signed [OUT_W-1:0] val    [0:1];
    side_t                   side1_reg;

    assign z_in[0] = hip_z;
    assign z_in[1] = HZ_W'(knee_z);

    for (genvar l = 0; l < 2; l++)
    begin : g_lane
        logic signed [46:0]   ph_next;
        logic        [44:0]   pl_next;
        logic signed [HZ_W:0] rsum;
        logic signed [63:0]   dsum;

        // split product for degrees, rounded shift for radians
        always_comb
        begin
            ph_next = $signed(z_in[l][HZ_W-1:17]) * $signed({1'b0, DEG_Q16});
            pl_next = z_in[l][16:0] * DEG_Q16;
            rsum    = {z_in[l][HZ_W-1], z_in[l]} + (HZ_W+1)'(1 << 17);
        end

        always_ff @(posedge clk)
        begin
            ph_reg[l] <= ph_next;
            pl_reg[l] <= pl_next;
            rr_reg[l] <= rsum[HZ_W:18];
        end

        // recombine the partial products
        always_comb
        begin
            dsum = $signed({ph_reg[l], 17'b0}) + $signed({19'b0, pl_reg[l]}) + DEG_HALF;
            val[l] = deg ? dsum[63:46] : rr_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            side1_reg <= '0;
        else
            side1_reg <= side;
    end

    // clamp and mask unreachable targets
    logic signed [OUT_W-1:0] hip_next;
    logic signed [OUT_W-1:0] knee_next;

    always_comb
    begin
        if (val[0] < -HIP_LIMIT)
            hip_next = -HIP_LIMIT;
        else if (val[0] > HIP_LIMIT)
            hip_next = HIP_LIMIT;
        else
            hip_next = val[0];

        if (val[1] < 0)
            knee_next = '0;
        else if (val[1] > KNEE_LIMIT)
            knee_next = KNEE_LIMIT;
        else
            knee_next = val[1];

        if (!side1_reg.reach)
        begin
            hip_next  = '0;
            knee_next = '0;
        end
    end

    logic                     done_reg;
    logic                     reach_reg;
    logic signed [HIP_W-1:0]  hip_reg;
    logic        [KNEE_W-1:0] knee_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= side1_reg.valid;
    end

    always_ff @(posedge clk)
    begin
        reach_reg <= side1_reg.reach;
        hip_reg   <= hip_next[HIP_W-1:0];
        knee_reg  <= knee_next[KNEE_W-1:0];
    end

    assign done       = done_reg;
    assign reachable  = reach_reg;
    assign hip_angle  = hip_reg;
    assign knee_angle = knee_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the two-link leg solver: predicts every joint angle beat.
// Depends on tlik_pkg and two_link_ik_solver_top; scoreboard class plus plain drive tasks.
`default_nettype none

module tb;
    import tlik_pkg::*;

    localparam int ITER = 16;
    localparam int LATENCY = ITER + 41;
    localparam longint CYCLE_LIMIT = 400000;
    localparam longint ANG_PI = 64'sd3373259426;
    localparam longint ANG_HALF_PI = 64'sd1686629713;
    localparam longint DEG_SCALE = 64'sd240315917;
    localparam longint ARCTAN_STEP [0:23] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768, 16384, 8192,
        4096, 2048, 1024, 512, 256, 128};

    // predicted joint angles for one foot target
    typedef struct {
        logic                    reach;
        logic signed [HIP_W-1:0] hip;
        logic [KNEE_W-1:0]       knee;
    } joints_t;

    class ik_scoreboard;
        longint  thigh;
        longint  shank;
        bit      degrees;
        joints_t pending[$];
        int      errors;
        int      checked;
        int      reached;

        function new();
            thigh = LEN_RESET;
            shank = LEN_RESET;
            degrees = 1'b1;
            errors = 0;
            checked = 0;
            reached = 0;
        endfunction

        function void set_reg(cfg_index_t idx, logic [LEN_W-1:0] val);
            case (idx)
                CFG_UPPER_LEN: thigh = val;
                CFG_LOWER_LEN: shank = val;
                CFG_DEG_MODE:  degrees = val[0];
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        // vectoring cordic, radians Q30
        function longint arctan2(longint yy, longint xx);
            longint z;
            longint t;
            longint dx;
            longint dy;
            z = 0;
            if (yy == 0)
                return (xx < 0) ? ANG_PI : 0;
            if (xx == 0)
                return (yy > 0) ? ANG_HALF_PI : -ANG_HALF_PI;
            if (xx < 0)
            begin
                if (yy > 0)
                begin
                    t = xx; xx = yy; yy = -t; z = ANG_HALF_PI;
                end
                else
                begin
                    t = xx; xx = -yy; yy = t; z = -ANG_HALF_PI;
                end
            end
            while ((xx < 0 ? -xx : xx) < (64'sd1 << 30) && (yy < 0 ? -yy : yy) < (64'sd1 << 30))
            begin
                xx = xx * 2;
                yy = yy * 2;
            end
            for (int i = 0; i < ITER && i < 24; i++)
            begin
                dx = yy >>> i;
                dy = xx >>> i;
                if (yy < 0)
                begin
                    xx = xx - dx; yy = yy + dy; z = z - ARCTAN_STEP[i];
                end
                else
                begin
                    xx = xx + dx; yy = yy - dy; z = z + ARCTAN_STEP[i];
                end
            end
            return z;
        endfunction

        function longint to_unit(longint z);
            if (degrees)
                return (z * DEG_SCALE + (64'sd1 << 45)) >>> 46;
            return (z + (64'sd1 << 17)) >>> 18;
        endfunction

        // note an accepted foot target and queue its expected angles
        function void note_target(logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy);
            longint  x, y, d2, n, p, s, hp, kn;
            longint unsigned un;
            joints_t e;
            x = fx;
            y = fy;
            d2 = x * x + y * y;
            e.reach = 1'b0;
            e.hip = '0;
            e.knee = '0;
            if (!(d2 > (thigh + shank) * (thigh + shank) || d2 < (thigh - shank) * (thigh - shank)))
            begin
                n = d2 - thigh * thigh - shank * shank;
                p = 2 * thigh * shank;
                un = (n < 0) ? -n : n;
                s = int_sqrt(longint'(p) * p - un * un);
                kn = to_unit(arctan2(s, n));
                hp = to_unit(arctan2(-y, x) - arctan2(s, d2 + thigh * thigh - shank * shank));
                if (kn < 0) kn = 0;
                if (kn > 12868) kn = 12868;
                if (hp < -25736) hp = -25736;
                if (hp > 25736) hp = 25736;
                e.reach = 1'b1;
                e.hip = HIP_W'(hp);
                e.knee = KNEE_W'(kn);
            end
            pending.push_back(e);
        endfunction

        // compare one result beat with the oldest expectation
        function void check_result(logic r, logic signed [HIP_W-1:0] h, logic [KNEE_W-1:0] k);
            joints_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result reach=%0b hip=%0d knee=%0d", $time, r, h, k);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (e.reach) reached++;
            if (r !== e.reach)
            begin
                $display("%0t: reachable expected %0b got %0b", $time, e.reach, r);
                errors++;
            end
            if (h !== e.hip)
            begin
                $display("%0t: hip_angle expected %0d got %0d", $time, e.hip, h);
                errors++;
            end
            if (k !== e.knee)
            begin
                $display("%0t: knee_angle expected %0d got %0d", $time, e.knee, k);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic signed [COORD_W-1:0] foot_x = '0;
    logic signed [COORD_W-1:0] foot_y = '0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LEN_W-1:0] cfg_data = '0;
    logic busy;
    logic done;
    logic reachable;
    logic signed [HIP_W-1:0] hip_angle;
    logic [KNEE_W-1:0] knee_angle;

    ik_scoreboard sb = new();
    longint cycles = 0;
    int sent = 0;

    two_link_ik_solver_top #(.CORDIC_ITERATIONS(ITER)) DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .foot_x(foot_x), .foot_y(foot_y),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .done(done), .reachable(reachable), .hip_angle(hip_angle), .knee_angle(knee_angle));

    always #1 clk = ~clk;

    // beat monitor and cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else if (rst_n)
        begin
            if (start && !busy)
                sb.note_target(foot_x, foot_y);
            if (done)
                sb.check_result(reachable, hip_angle, knee_angle);
        end
    end

    // one register write, block idle
    task automatic write_reg(cfg_index_t idx, logic [LEN_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_links(int up, int lo, bit deg);
        write_reg(CFG_UPPER_LEN, LEN_W'(up));
        write_reg(CFG_LOWER_LEN, LEN_W'(lo));
        write_reg(CFG_DEG_MODE, LEN_W'(deg));
    endtask

    // one foot beat, held until taken
    task automatic send_foot(int x, int y);
        foot_x = COORD_W'(x);
        foot_y = COORD_W'(y);
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic pause(int n);
        start = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // wait until every expected beat is back, then let the pipe drain
    task automatic drain();
        start = 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic int coord_near(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v;
    endfunction

    // random bursts: mostly targets inside the workspace box, some full range
    task automatic random_phase(int count);
        int span, left, burst;
        span = int'(sb.thigh + sb.shank);
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 24);
            for (int i = 0; i < burst && left > 0; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_foot(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768);
                else
                    send_foot(coord_near(span), coord_near(span));
                left--;
            end
            if ($urandom_range(0, 2) != 0)
                pause($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed targets at reset lengths
        send_foot(0, 0);
        send_foot(3200, 0);
        send_foot(0, 3200);
        send_foot(-3200, 0);
        send_foot(0, -3200);
        send_foot(3201, 0);
        send_foot(2262, 2262);
        send_foot(-2262, 2263);
        send_foot(1, 0);
        send_foot(0, 1);
        send_foot(32767, 32767);
        send_foot(-32768, -32768);
        send_foot(-32768, 32767);
        pause(3);
        send_foot(1000, -1500);
        send_foot(-2000, -1000);
        drain();

        // radians, maximal links: every coordinate reachable
        set_links(32767, 32767, 1'b0);
        send_foot(-32768, -32768);
        send_foot(32767, 0);
        send_foot(0, 0);
        send_foot(-32768, 0);
        random_phase(250);
        drain();

        set_links(1, 32767, 1'b1);
        send_foot(32766, 0);
        send_foot(0, -32768);
        random_phase(250);
        drain();

        set_links(32767, 1, 1'b0);
        random_phase(250);
        drain();

        set_links(1, 1, 1'b1);
        send_foot(2, 0);
        send_foot(0, 0);
        random_phase(150);
        drain();

        set_links(LEN_RESET, LEN_RESET, 1'b0);
        random_phase(300);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            set_links($urandom_range(1, 32767), $urandom_range(1, 20000), ph[0]);
            random_phase(200);
            drain();
        end

        $display("sent %0d foot targets over 10 link settings in both angle units", sent);
        $display("checked %0d results, %0d of them reachable", sb.checked, sb.reached);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

`default_nettype wire

// ===== two_link_ik_solver_top.f =====
design/tlik_pkg.sv
design/tlik_isqrt.sv
design/tlik_cordic.sv
design/tlik_out.sv
design/two_link_ik_solver_top.sv
verif/tb.sv
